FILE: hdl/cbs_pkg.sv
// Shared types, constants, arithmetic helpers and the control store of the Bezier subdivider.
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

  localparam int MaxLevels  = 4;
  localparam int CoordBits  = 16;
  localparam int StoreDepth = 3 * (2 ** MaxLevels) + 1;
  localparam int AddrBits   = $clog2(StoreDepth);
  localparam int SpanBits   = MaxLevels + 1;
  localparam int LvlBits    = 3;
  localparam int PDataBits  = 32;
  localparam int PAddrBits  = 3;
  localparam int StepBits   = 4;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl_a_x;
    coord_t ctrl_a_y;
    coord_t ctrl_b_x;
    coord_t ctrl_b_y;
    coord_t end_x;
    coord_t end_y;
  } in_beat_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } out_beat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // Step addresses of the control program
  localparam logic [StepBits-1:0] StepIdle = 4'd0;
  localparam logic [StepBits-1:0] StepLd0  = 4'd1;
  localparam logic [StepBits-1:0] StepLd1  = 4'd2;
  localparam logic [StepBits-1:0] StepLd2  = 4'd3;
  localparam logic [StepBits-1:0] StepLd3  = 4'd4;
  localparam logic [StepBits-1:0] StepRd01 = 4'd5;
  localparam logic [StepBits-1:0] StepRd23 = 4'd6;
  localparam logic [StepBits-1:0] StepMid  = 4'd7;
  localparam logic [StepBits-1:0] StepQq   = 4'd8;
  localparam logic [StepBits-1:0] StepWr1  = 4'd9;
  localparam logic [StepBits-1:0] StepWr2  = 4'd10;
  localparam logic [StepBits-1:0] StepWr3  = 4'd11;
  localparam logic [StepBits-1:0] StepWr4  = 4'd12;
  localparam logic [StepBits-1:0] StepWr5  = 4'd13;
  localparam logic [StepBits-1:0] StepEmit = 4'd14;

  // Address offsets from the curve base, in units of the current span d (h = d/2)
  typedef enum logic [2:0] {
    OffZero = 3'd0,
    OffH    = 3'd1,
    OffD    = 3'd2,
    OffH3   = 3'd3,
    OffD2   = 3'd4,
    OffH5   = 3'd5,
    OffD3   = 3'd6
  } off_e;

  typedef enum logic [3:0] {
    SrcIn0 = 4'd0,
    SrcIn1 = 4'd1,
    SrcIn2 = 4'd2,
    SrcIn3 = 4'd3,
    SrcM01 = 4'd4,
    SrcQ0  = 4'd5,
    SrcC   = 4'd6,
    SrcQ1  = 4'd7,
    SrcM23 = 4'd8
  } src_e;

  typedef enum logic [1:0] {
    JmpNext  = 2'd0,
    JmpWait  = 2'd1,
    JmpCurve = 2'd2,
    JmpEmit  = 2'd3
  } jmp_e;

  typedef struct packed {
    logic                we;
    src_e                wsrc;
    off_e                woff;
    off_e                rda_off;
    off_e                rdb_off;
    logic                lat_p01;
    logic                lat_m;
    logic                lat_q;
    jmp_e                jmp;
    logic [StepBits-1:0] target;
  } ucw_t;

  // floor((a + b) / 2)
  function automatic coord_t half_floor(coord_t a, coord_t b);
    logic signed [CoordBits:0] s;
    s = {a[CoordBits-1], a} + {b[CoordBits-1], b};
    return s[CoordBits:1];
  endfunction

  function automatic pt_t mid_pt(pt_t a, pt_t b);
    pt_t r;
    r.x = half_floor(a.x, b.x);
    r.y = half_floor(a.y, b.y);
    return r;
  endfunction

  function automatic ucw_t ucode_rom(logic [StepBits-1:0] step);
    ucw_t w;
    w = '0;
    case (step)
      StepIdle: begin
        w.jmp = JmpWait;
      end
      StepLd0: begin
        w.we = 1'b1; w.wsrc = SrcIn0; w.woff = OffZero;
      end
      StepLd1: begin
        w.we = 1'b1; w.wsrc = SrcIn1; w.woff = OffD;
      end
      StepLd2: begin
        w.we = 1'b1; w.wsrc = SrcIn2; w.woff = OffD2;
      end
      StepLd3: begin
        w.we = 1'b1; w.wsrc = SrcIn3; w.woff = OffD3;
      end
      StepRd01: begin
        w.rda_off = OffZero; w.rdb_off = OffD;
      end
      StepRd23: begin
        w.rda_off = OffD2; w.rdb_off = OffD3; w.lat_p01 = 1'b1;
      end
      StepMid: begin
        w.lat_m = 1'b1;
      end
      StepQq: begin
        w.lat_q = 1'b1;
      end
      StepWr1: begin
        w.we = 1'b1; w.wsrc = SrcM01; w.woff = OffH;
      end
      StepWr2: begin
        w.we = 1'b1; w.wsrc = SrcQ0; w.woff = OffD;
      end
      StepWr3: begin
        w.we = 1'b1; w.wsrc = SrcC; w.woff = OffH3;
      end
      StepWr4: begin
        w.we = 1'b1; w.wsrc = SrcQ1; w.woff = OffD2;
      end
      StepWr5: begin
        w.we = 1'b1; w.wsrc = SrcM23; w.woff = OffH5;
        w.jmp = JmpCurve; w.target = StepRd01;
      end
      StepEmit: begin
        w.jmp = JmpEmit; w.target = StepIdle;
      end
      default: begin
        w.jmp = JmpNext;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cbs_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 49
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] ra_addr_i,
  output logic      [Width-1:0]         ra_data_o,
  input  wire logic [$clog2(Depth)-1:0] rb_addr_i,
  output logic      [Width-1:0]         rb_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/cubic_bezier_uniform_subdivider.sv
// Top level: microcoded de Casteljau midpoint subdivider for one cubic Bezier curve per beat.
// With n = 2^levels sub-curves, each split writes five points through the single write port of
//   the point store; a new curve is taken only once its last point is read out.
// Points leave one per cycle while the consumer keeps ready high.
// Reset: sequencer to idle, split_levels to 1, output queue empty; point store needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_uniform_subdivider import cbs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_beat_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_beat_t                 out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PAddrBits-1:0] paddr,
  input  wire logic [PDataBits-1:0] pwdata,
  output logic      [PDataBits-1:0] prdata,
  output logic                      pready
);

  // register index, taken from the word address bit
  localparam logic RegSplitLevels = 1'b0;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic [LvlBits-1:0] lvl_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= LvlBits'(1);
    end else if (cfg_we && (paddr[2] == RegSplitLevels)) begin
      lvl_q <= pwdata[LvlBits-1:0];
    end
  end

  assign prdata = (paddr[2] == RegSplitLevels) ?
                  {{(PDataBits-LvlBits){1'b0}}, lvl_q} : '0;

  // Level clamp: zero acts as one, anything above the maximum saturates
  logic [LvlBits-1:0]  lvl_eff;
  logic [SpanBits-1:0] n_new;

  always_comb begin
    if (lvl_q == '0) begin
      lvl_eff = LvlBits'(1);
    end else if (lvl_q > LvlBits'(MaxLevels)) begin
      lvl_eff = LvlBits'(MaxLevels);
    end else begin
      lvl_eff = lvl_q;
    end
    n_new = SpanBits'(1) << lvl_eff;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter, control store and jump logic
  // ---------------------------------------------------------------------------
  logic [StepBits-1:0] step_q, step_d;
  ucw_t                ucw;
  logic                in_fire;

  // Loop state: base of the curve being split, its span d, and n for this beat
  logic [AddrBits-1:0] base_q, base_d;
  logic [SpanBits-1:0] d_q, d_d;
  logic [SpanBits-1:0] n_q;
  logic [AddrBits-1:0] last_idx;
  logic [AddrBits-1:0] next_base;
  logic [SpanBits-1:0] d_half;
  logic                level_end;
  logic                curve_more;

  // emitter handshake with the sequencer
  logic                issue;
  logic                emit_last;

  function automatic logic [AddrBits-1:0] off_val(off_e o, logic [SpanBits-1:0] d);
    logic [AddrBits-1:0] d6;
    logic [AddrBits-1:0] h6;
    logic [AddrBits-1:0] r;
    d6 = AddrBits'(d);
    h6 = d6 >> 1;
    case (o)
      OffZero: r = '0;
      OffH:    r = h6;
      OffD:    r = d6;
      OffH3:   r = h6 + (h6 << 1);
      OffD2:   r = d6 << 1;
      OffH5:   r = h6 + (h6 << 2);
      OffD3:   r = d6 + (d6 << 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign ucw        = ucode_rom(step_q);
  assign in_ready_o = (step_q == StepIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  assign last_idx   = AddrBits'(n_q) + (AddrBits'(n_q) << 1);
  assign next_base  = base_q + off_val(OffD3, d_q);
  assign d_half     = d_q >> 1;
  assign level_end  = (next_base == last_idx);
  // more curves on this level, or another level still to go
  assign curve_more = !level_end || (d_half != SpanBits'(1));

  always_comb begin
    step_d = step_q;
    case (ucw.jmp)
      JmpNext:  step_d = step_q + StepBits'(1);
      JmpWait:  step_d = in_fire ? (step_q + StepBits'(1)) : step_q;
      JmpCurve: step_d = curve_more ? ucw.target : (step_q + StepBits'(1));
      JmpEmit:  step_d = (issue && emit_last) ? ucw.target : step_q;
      default:  step_d = ucw.target;
    endcase
  end

  always_comb begin
    base_d = base_q;
    d_d    = d_q;
    if (in_fire) begin
      base_d = '0;
      d_d    = n_new;
    end else if (ucw.jmp == JmpCurve) begin
      if (level_end) begin
        base_d = '0;
        d_d    = d_half;
      end else begin
        base_d = next_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
      base_q <= '0;
      d_q    <= SpanBits'(1);
      n_q    <= SpanBits'(2);
    end else begin
      step_q <= step_d;
      base_q <= base_d;
      d_q    <= d_d;
      if (in_fire) begin
        n_q <= n_new;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: input hold, point store, midpoint registers
  // ---------------------------------------------------------------------------
  in_beat_t            in_q;
  pt_t                 p0_q, p1_q;
  pt_t                 m01_q, m12_q, m23_q;
  pt_t                 q0_q, q1_q;
  pt_t                 c_pt;
  pt_t                 wdata;
  pt_t                 rd_a, rd_b;
  logic [AddrBits-1:0] waddr;
  logic [AddrBits-1:0] ra_addr;
  logic [AddrBits-1:0] rb_addr;
  logic                emit_on;
  logic [AddrBits-1:0] emit_idx_q;

  assign c_pt    = mid_pt(q0_q, q1_q);
  assign emit_on = (step_q == StepEmit);
  assign waddr   = base_q + off_val(ucw.woff, d_q);
  // port A streams the result during the emit step
  assign ra_addr = emit_on ? emit_idx_q : (base_q + off_val(ucw.rda_off, d_q));
  assign rb_addr = base_q + off_val(ucw.rdb_off, d_q);

  always_comb begin
    case (ucw.wsrc)
      SrcIn0:  wdata = pt_t'{x: in_q.start_x,  y: in_q.start_y};
      SrcIn1:  wdata = pt_t'{x: in_q.ctrl_a_x, y: in_q.ctrl_a_y};
      SrcIn2:  wdata = pt_t'{x: in_q.ctrl_b_x, y: in_q.ctrl_b_y};
      SrcIn3:  wdata = pt_t'{x: in_q.end_x,    y: in_q.end_y};
      SrcM01:  wdata = m01_q;
      SrcQ0:   wdata = q0_q;
      SrcC:    wdata = c_pt;
      SrcQ1:   wdata = q1_q;
      SrcM23:  wdata = m23_q;
      default: wdata = m01_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    if (ucw.lat_p01) begin
      p0_q <= rd_a;
      p1_q <= rd_b;
    end
    // p2 and p3 come straight off the read ports
    if (ucw.lat_m) begin
      m01_q <= mid_pt(p0_q, p1_q);
      m12_q <= mid_pt(p1_q, rd_a);
      m23_q <= mid_pt(rd_a, rd_b);
    end
    if (ucw.lat_q) begin
      q0_q <= mid_pt(m01_q, m12_q);
      q1_q <= mid_pt(m12_q, m23_q);
    end
  end

  cbs_ram #(
    .Width($bits(pt_t)),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ucw.we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .ra_addr_i(ra_addr),
    .ra_data_o(rd_a),
    .rb_addr_i(rb_addr),
    .rb_data_o(rd_b)
  );

  // ---------------------------------------------------------------------------
  // Emitter: read ahead into a two-beat output queue; while ready is held high, one point per cycle
  // ---------------------------------------------------------------------------
  logic       inflight_q;
  logic       infl_last_q;
  logic [1:0] cnt_q;
  logic       wr_ptr_q, rd_ptr_q;
  out_beat_t  fifo_q [2];
  logic [1:0] occ;
  logic       pop;
  logic       push;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign push        = inflight_q;
  // queued beats plus the read in flight; only issue if a slot is sure to be free
  assign occ         = cnt_q + 2'(inflight_q);
  assign issue       = emit_on && ((occ < 2'd2) || pop);
  assign emit_last   = (emit_idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q  <= 1'b0;
      infl_last_q <= 1'b0;
      emit_idx_q  <= '0;
      cnt_q       <= 2'd0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
    end else begin
      inflight_q <= issue;
      if (issue) begin
        infl_last_q <= emit_last;
        emit_idx_q  <= emit_last ? '0 : (emit_idx_q + AddrBits'(1));
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= out_beat_t'{point_x: rd_a.x, point_y: rd_a.y,
                                      last_point: infl_last_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= 2'd2)
    else $error("output queue credit exceeded");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q && (cnt_q == 2'd2)) |-> pop)
    else $error("read data landing on a full output queue");

  a_span_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(d_q))
    else $error("split span is not a power of two");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucw.we |-> (waddr < AddrBits'(StoreDepth)))
    else $error("point store write out of range");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && emit_last) |=> (step_q == StepIdle))
    else $error("sequencer did not return to idle after last point");

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((step_q == StepLd0) && (base_q == '0)))
    else $error("accepted beat did not start the load");

endmodule

`default_nettype wire

FILE: dv/cbs_point_checker.sv
// Checker for the Bezier subdivider: predicts emitted control points and compares them.
`timescale 1ns / 1ps

module cbs_point_checker import cbs_pkg::*; #(
  parameter logic [PAddrBits-1:0] LEVELS_ADDR = '0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire in_beat_t             in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire out_beat_t            out_data_i,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PAddrBits-1:0] paddr,
  input  wire logic [PDataBits-1:0] pwdata,
  input  wire logic                 pready,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        points_o
);

  out_beat_t          point_q[$];
  out_beat_t          want;
  logic [LvlBits-1:0] levels_reg;
  int                 fails;
  int                 checked;

  // floor((a + b) / 2) via 32-bit sum
  function automatic coord_t midpoint(coord_t a, coord_t b);
    int s;
    s = int'(a) + int'(b);
    return coord_t'(s >>> 1);
  endfunction

  task automatic predict_points(input in_beat_t c);
    coord_t    grid [2][StoreDepth];
    coord_t    p0, p1, p2, p3, m01, m12, m23, q0, q1, ctr;
    out_beat_t pt;
    int        lv, n, d, h, base;
    lv = (levels_reg == 0) ? 1 : ((levels_reg > MaxLevels) ? MaxLevels : int'(levels_reg));
    n = 1 << lv;
    grid[0][0]     = c.start_x;
    grid[1][0]     = c.start_y;
    grid[0][n]     = c.ctrl_a_x;
    grid[1][n]     = c.ctrl_a_y;
    grid[0][2 * n] = c.ctrl_b_x;
    grid[1][2 * n] = c.ctrl_b_y;
    grid[0][3 * n] = c.end_x;
    grid[1][3 * n] = c.end_y;
    d = n;
    while (d > 1) begin
      h = d / 2;
      for (int k = 0; k < n / d; k++) begin
        base = 3 * d * k;
        for (int a = 0; a < 2; a++) begin
          p0  = grid[a][base];
          p1  = grid[a][base + d];
          p2  = grid[a][base + 2 * d];
          p3  = grid[a][base + 3 * d];
          m01 = midpoint(p0, p1);
          m12 = midpoint(p1, p2);
          m23 = midpoint(p2, p3);
          q0  = midpoint(m01, m12);
          q1  = midpoint(m12, m23);
          ctr = midpoint(q0, q1);
          grid[a][base + h]     = m01;
          grid[a][base + d]     = q0;
          grid[a][base + 3 * h] = ctr;
          grid[a][base + 2 * d] = q1;
          grid[a][base + 5 * h] = m23;
        end
      end
      d = h;
    end
    for (int i = 0; i <= 3 * n; i++) begin
      pt.point_x    = grid[0][i];
      pt.point_y    = grid[1][i];
      pt.last_point = (i == 3 * n);
      point_q.push_back(pt);
    end
  endtask

  initial begin
    fails   = 0;
    checked = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      point_q.delete();
      levels_reg = 3'd1;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LEVELS_ADDR) begin
        levels_reg = pwdata[LvlBits-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (point_q.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                   out_data_i.point_x, out_data_i.point_y, out_data_i.last_point);
          fails++;
        end else begin
          want = point_q.pop_front();
          if (out_data_i.point_x !== want.point_x) begin
            $display("%0t: point %0d x expected %0d got %0d", $time, checked,
                     want.point_x, out_data_i.point_x);
            fails++;
          end
          if (out_data_i.point_y !== want.point_y) begin
            $display("%0t: point %0d y expected %0d got %0d", $time, checked,
                     want.point_y, out_data_i.point_y);
            fails++;
          end
          if (out_data_i.last_point !== want.last_point) begin
            $display("%0t: point %0d last expected %0b got %0b", $time, checked,
                     want.last_point, out_data_i.last_point);
            fails++;
          end
        end
        checked++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_points(in_data_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= point_q.size();
    points_o     <= checked;
  end

endmodule

FILE: dv/tb_cubic_bezier_uniform_subdivider.sv
// Testbench top for the Bezier subdivider: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_cubic_bezier_uniform_subdivider;
  import cbs_pkg::*;

  // Address of the split level register (first and only register)
  localparam logic [PAddrBits-1:0] LevelsAddr = PAddrBits'(0);
  // Number of random curves to push after the directed part
  localparam int RandomCurves = 184;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_beat_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_beat_t            out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PAddrBits-1:0] paddr;
  logic [PDataBits-1:0] pwdata;
  logic [PDataBits-1:0] prdata;
  logic                 pready;

  int   fail_count;
  int   pending;
  int   points_seen;
  int   curves_sent;
  int   random_sent;
  int   burst_len;
  bit   steady;        // when set, neither side inserts gaps
  logic [7:0] lvl_seen; // which register values have been written

  cubic_bezier_uniform_subdivider uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  cbs_point_checker #(.LEVELS_ADDR(LevelsAddr)) point_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .points_o     (points_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run (four levels, full output
  // stalls and maximum sender gaps on every curve).
  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Output side: per point, a random stall with ready low (none when steady), then hold ready until the beat moves.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Coordinate picker: half full-range noise, the rest the rails and values near zero
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      3:       return 16'sh7fff;
      4:       return 16'sh8000;
      5:       return coord_t'($urandom_range(0, 64)) - 16'sd32;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic in_beat_t make_curve();
    logic [$bits(in_beat_t)-1:0] raw;
    for (int i = 0; i < 8; i++) raw[CoordBits*i +: CoordBits] = pick_coord();
    return in_beat_t'(raw);
  endfunction

  // Hold valid low for a number of cycles (zero keeps back-to-back beats)
  task automatic rest(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic send_curve(input in_beat_t c);
    rest(steady ? 0 : $urandom_range(0, 14));
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    curves_sent++;
  endtask

  // Let every expected point leave, plus slack for the sequencer
  task automatic drain();
    rest(1);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // APB write: setup then access; upper data bits are junk, only [2:0] count
  task automatic write_levels(input logic [LvlBits-1:0] lvl);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LevelsAddr;
    pwdata  <= {$urandom} & ~PDataBits'(7) | PDataBits'(lvl);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lvl_seen[lvl] = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    curves_sent = 0;
    random_sent = 0;
    steady      = 1'b0;
    lvl_seen    = 8'b0000_0010; // reset value of one level

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset level: rails, alternating rails (largest point-to-point steps), -1/+1 rounding
    send_curve(in_beat_t'({8{16'h7fff}}));
    send_curve(in_beat_t'({8{16'h8000}}));
    send_curve(in_beat_t'({4{16'h7fff, 16'h8000}}));
    send_curve(in_beat_t'({2{32'h7fff7fff, 32'h80008000}}));
    send_curve(in_beat_t'({8{16'hffff}}));
    send_curve(in_beat_t'({4{16'hffff, 16'h0001}}));
    send_curve(in_beat_t'({16'h0000, 16'h0000, 16'h0010, 16'h0030,
                           16'h0050, 16'h0030, 16'h0060, 16'h0000}));
    drain();

    // Register zero behaves as one level
    write_levels(3'd0);
    send_curve(in_beat_t'({16'h0000, 16'h0000, 16'h0010, 16'h0030,
                           16'h0050, 16'h0030, 16'h0060, 16'h0000}));
    send_curve(in_beat_t'({4{16'h8000, 16'h7fff}}));
    drain();

    // Values above the maximum saturate to four levels
    write_levels(3'd5);
    send_curve(in_beat_t'({8{16'h7fff}}));
    send_curve(make_curve());
    drain();
    write_levels(3'd7);
    send_curve(in_beat_t'({4{16'h7fff, 16'h8000}}));
    drain();

    // Deepest legal setting, then the middle ones
    write_levels(3'd4);
    send_curve(in_beat_t'({8{16'h8000}}));
    send_curve(in_beat_t'({4{16'h8001, 16'h7ffe}}));
    drain();
    write_levels(3'd3);
    send_curve(make_curve());
    drain();
    write_levels(3'd2);
    send_curve(in_beat_t'({4{16'hffff, 16'h0001}}));
    drain();

    // Random phases; each one starts from an idle block (sender waits for
    // every point), so the register write lands between curves.
    for (int phase = 0; random_sent < RandomCurves; phase++) begin
      if ($urandom_range(0, 3) == 0) write_levels(LvlBits'($urandom_range(0, 7)));
      else write_levels(LvlBits'($urandom_range(1, 2)));
      steady    = (phase % 4 == 3);
      burst_len = $urandom_range(8, 24);
      if (burst_len > RandomCurves - random_sent) burst_len = RandomCurves - random_sent;
      repeat (burst_len) begin
        send_curve(make_curve());
        random_sent++;
      end
      drain();
    end
    steady = 1'b0;

    drain();
    repeat (40) @(negedge clk_i);

    $display("Summary: %0d curves sent, %0d points compared.", curves_sent, points_seen);
    $display("Split level register values written (bit per value 7..0): %b", lvl_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/cbs_pkg.sv
hdl/cbs_ram.sv
hdl/cubic_bezier_uniform_subdivider.sv
dv/cbs_point_checker.sv
dv/tb_cubic_bezier_uniform_subdivider.sv
